/* hw/rtl/spib_pkg.sv */
// Shared types, constants and register indexes of the seek point index builder.
package spib_pkg;

	localparam int MAX_POINTS   = 4096;
	localparam int MAX_PER_ITEM = 64;

	localparam int PM_W  = 13;
	localparam int EN_W  = 12;
	localparam int CNT_W = $clog2(MAX_PER_ITEM + 1);
	localparam int IDX_W = 3;
	localparam int CFG_W = 32;

	localparam logic [IDX_W-1:0] REG_FRAME_STEP      = 3'd0;
	localparam logic [IDX_W-1:0] REG_SAMPLE_STEP     = 3'd1;
	localparam logic [IDX_W-1:0] REG_SAMPLE_FRACTION = 3'd2;
	localparam logic [IDX_W-1:0] REG_FRAME_RATE      = 3'd3;
	localparam logic [IDX_W-1:0] REG_ENTRY_LIMIT     = 3'd4;
	localparam logic [IDX_W-1:0] REG_AUDIO_ENABLED   = 3'd5;
	localparam logic [IDX_W-1:0] REG_STREAM_START    = 3'd6;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_D    = 8'h64;
	localparam logic [7:0] CH_C    = 8'h63;
	localparam logic [7:0] CH_B    = 8'h62;
	localparam logic [7:0] CH_W    = 8'h77;

	typedef struct packed {
		logic [15:0] frame_step;
		logic [31:0] sample_step;
		logic [15:0] sample_step_fraction;
		logic [9:0]  frame_rate;
		logic [12:0] entry_limit;
		logic        audio_enabled;
		logic [16:0] stream_start;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic step;
		logic reload;
		logic load_out;
		logic commit;
		logic out_last;
		logic out_over;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic due;
	} dp_sts_t;

	typedef struct packed {
		logic [EN_W-1:0] entry_number;
		logic [31:0]     file_offset;
		logic [31:0]     videos_before;
		logic [31:0]     audio_before;
		logic            last;
		logic            table_full;
		logic            overflow;
	} res_t;

endpackage

/* hw/rtl/spib_if.sv */
// Valid/ready channel interfaces for index entries and seek entries.
interface spib_in_if;
	logic        valid;
	logic        ready;
	logic        restart;
	logic [31:0] chunk_tag;
	logic [31:0] chunk_offset;
	logic [31:0] chunk_length;

	modport source (output valid, restart, chunk_tag, chunk_offset, chunk_length,
		input ready);
	modport sink (input valid, restart, chunk_tag, chunk_offset, chunk_length,
		output ready);
endinterface

interface spib_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] entry_number;
	logic [31:0] file_offset;
	logic [31:0] videos_before;
	logic [31:0] audio_before;
	logic        last;
	logic        table_full;
	logic        overflow;

	modport source (output valid, entry_number, file_offset, videos_before, audio_before,
		last, table_full, overflow, input ready);
	modport sink (input valid, entry_number, file_offset, videos_before, audio_before,
		last, table_full, overflow, output ready);
endinterface

/* hw/rtl/spib_cfg.sv */
// Configuration register file of the seek point index builder.
module spib_cfg import spib_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_step           <= 16'd1;
			cfg_q.sample_step          <= '0;
			cfg_q.sample_step_fraction <= '0;
			cfg_q.frame_rate           <= 10'd25;
			cfg_q.entry_limit          <= 13'd1;
			cfg_q.audio_enabled        <= 1'b0;
			cfg_q.stream_start         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_STEP:      cfg_q.frame_step           <= cfg_data[15:0];
				REG_SAMPLE_STEP:     cfg_q.sample_step          <= cfg_data[31:0];
				REG_SAMPLE_FRACTION: cfg_q.sample_step_fraction <= cfg_data[15:0];
				REG_FRAME_RATE:      cfg_q.frame_rate           <= cfg_data[9:0];
				REG_ENTRY_LIMIT:     cfg_q.entry_limit          <= cfg_data[12:0];
				REG_AUDIO_ENABLED:   cfg_q.audio_enabled        <= cfg_data[0];
				REG_STREAM_START:    cfg_q.stream_start         <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/spib_datapath.sv */
// Datapath: running counters, working copy of the targets, step unit and result register.
module spib_datapath import spib_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic        restart,
	input  logic [31:0] chunk_tag,
	input  logic [31:0] chunk_offset,
	input  logic [31:0] chunk_length,
	output res_t        res
);

	logic [31:0]     video_count_q, audio_bytes_q, next_frame_q, next_sample_q, offset_base_q;
	logic [15:0]     sample_fraction_q;
	logic [PM_W-1:0] points_made_q;

	logic [31:0]     wf_q, ws_q, wf_d, ws_d;
	logic [15:0]     wfr_q, wfr_d;
	logic [PM_W-1:0] wp_q, wp_d;

	logic [31:0] off_q, len_q, asum_q;
	logic        vid_q, aud_q;
	res_t        res_q;

	logic [PM_W-1:0] lim;
	logic [15:0]     fsum, fnew;
	logic            fge;
	logic [PM_W-1:0] wp_inc;
	logic [7:0]      t0, t1, t2, t3;
	logic            is_vid, is_aud;

	assign t0 = chunk_tag[7:0];
	assign t1 = chunk_tag[15:8];
	assign t2 = chunk_tag[23:16];
	assign t3 = chunk_tag[31:24];
	assign is_vid = (t0 == CH_ZERO) && (t1 == CH_ZERO) && (t2 == CH_D)
		&& ((t3 == CH_C) || (t3 == CH_B));
	assign is_aud = cfg.audio_enabled && (t0 == CH_ZERO) && (t1 == CH_ONE)
		&& (t2 == CH_W) && (t3 == CH_B);

	assign lim = (cfg.entry_limit > PM_W'(MAX_POINTS)) ? PM_W'(MAX_POINTS) : cfg.entry_limit;

	assign fsum   = wfr_q + cfg.sample_step_fraction;
	assign fge    = fsum >= {6'd0, cfg.frame_rate};
	assign fnew   = fge ? fsum - {6'd0, cfg.frame_rate} : fsum;
	assign wp_inc = wp_q + PM_W'(1);

	always_comb begin
		wf_d  = wf_q;
		ws_d  = ws_q;
		wfr_d = wfr_q;
		wp_d  = wp_q;
		if (cmd.prep || cmd.reload) begin
			wf_d  = next_frame_q;
			ws_d  = next_sample_q;
			wfr_d = sample_fraction_q;
			wp_d  = points_made_q;
		end else if (cmd.step) begin
			wf_d  = wf_q + {16'd0, cfg.frame_step};
			ws_d  = ws_q + cfg.sample_step + {31'd0, fge};
			wfr_d = fnew;
			wp_d  = wp_inc;
		end
	end

	always_ff @(posedge clk) begin
		wf_q  <= wf_d;
		ws_q  <= ws_d;
		wfr_q <= wfr_d;
		wp_q  <= wp_d;
		if (cmd.capture) begin
			off_q <= chunk_offset;
			len_q <= chunk_length;
			vid_q <= is_vid;
			aud_q <= is_aud;
		end
		if (cmd.prep) begin
			asum_q <= audio_bytes_q + len_q;
		end
		if (cmd.load_out) begin
			res_q.entry_number  <= wp_q[EN_W-1:0];
			res_q.file_offset   <= offset_base_q + off_q;
			res_q.videos_before <= video_count_q;
			res_q.audio_before  <= audio_bytes_q;
			res_q.last          <= cmd.out_last;
			res_q.table_full    <= wp_inc >= lim;
			res_q.overflow      <= cmd.out_over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_count_q     <= '0;
			audio_bytes_q     <= '0;
			next_frame_q      <= '0;
			next_sample_q     <= '0;
			sample_fraction_q <= '0;
			points_made_q     <= '0;
			offset_base_q     <= '0;
		end else if (cmd.capture && restart) begin
			video_count_q     <= '0;
			audio_bytes_q     <= '0;
			next_frame_q      <= '0;
			next_sample_q     <= '0;
			sample_fraction_q <= '0;
			points_made_q     <= '0;
			offset_base_q     <= '0;
		end else if (cmd.prep) begin
			if ((video_count_q == '0) && (audio_bytes_q == '0) && (points_made_q == '0)) begin
				offset_base_q <= (off_q < {15'd0, cfg.stream_start})
					? {15'd0, cfg.stream_start} - 32'd4 : '0;
			end
		end else if (cmd.commit) begin
			next_frame_q      <= wf_d;
			next_sample_q     <= ws_d;
			sample_fraction_q <= wfr_d;
			points_made_q     <= wp_d;
			video_count_q     <= video_count_q + {31'd0, vid_q};
			if (aud_q) begin
				audio_bytes_q <= asum_q;
			end
		end
	end

	assign sts.full = points_made_q >= lim;
	assign sts.due  = (wp_q < lim)
		&& ((vid_q && (video_count_q >= wf_q)) || (aud_q && (asum_q > ws_q)));
	assign res = res_q;

endmodule

/* hw/rtl/spib_ctrl.sv */
// Controller: item sequencing through a counting pass and an emitting pass.
module spib_ctrl import spib_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    out_ready,
	output logic    out_valid,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PREP  = 2'd1;
	localparam logic [1:0] ST_COUNT = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, n_q, n_d, k_q, k_d;
	logic             over_q, over_d, ovalid_q, ovalid_d;
	logic             accept, fire, last;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign fire     = (state_q == ST_EMIT) && (!ovalid_q || out_ready);
	assign last     = CNT_W'(k_q + CNT_W'(1)) == n_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		n_d     = n_q;
		k_d     = k_q;
		over_d  = over_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				if (sts.full) begin
					state_d = ST_IDLE;
				end else begin
					cmd.prep = 1'b1;
					cnt_d    = '0;
					state_d  = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (sts.due && (cnt_q != CNT_W'(MAX_PER_ITEM))) begin
					cmd.step = 1'b1;
					cnt_d    = cnt_q + CNT_W'(1);
				end else begin
					n_d    = cnt_q;
					over_d = sts.due;
					if (cnt_q == '0) begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.reload = 1'b1;
						k_d        = '0;
						state_d    = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (fire) begin
					cmd.load_out = 1'b1;
					cmd.step     = 1'b1;
					cmd.out_last = last;
					cmd.out_over = over_q;
					k_d          = k_q + CNT_W'(1);
					if (last) begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fire) begin
			ovalid_d = 1'b1;
		end else if (out_ready) begin
			ovalid_d = 1'b0;
		end else begin
			ovalid_d = ovalid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			n_q      <= '0;
			k_q      <= '0;
			over_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			n_q      <= n_d;
			k_q      <= k_d;
			over_q   <= over_d;
			ovalid_q <= ovalid_d;
		end
	end

	assign out_valid = ovalid_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PER_ITEM))
		else $error("count pass exceeded the per-item cap");
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ((n_q != '0) && (k_q < n_q)))
		else $error("emit index outside the counted range");
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_PREP))
		else $error("accepted beat did not start preparation");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last) |=> ((state_q == ST_IDLE) && out_valid))
		else $error("final seek beat did not return to idle");
`endif

endmodule

/* hw/rtl/seek_point_index_builder_top.sv */
// Top level of the seek point index builder.
// One index entry is handled at a time: accept, a preparation state, a counting
// pass for an entry yielding n seek points (n at most 64), then an emit pass of
// n registered seek beats, which stalls while a held beat is not taken. A full
// table returns to idle from preparation, an entry with no point from the counting pass.
// Reset is asynchronous and active low: config registers to reset values, counters zero.
module seek_point_index_builder_top import spib_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	spib_in_if.sink          in_ch,
	spib_out_if.source       out_ch
);

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;
	res_t    res;

	spib_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spib_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	spib_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.restart      (in_ch.restart),
		.chunk_tag    (in_ch.chunk_tag),
		.chunk_offset (in_ch.chunk_offset),
		.chunk_length (in_ch.chunk_length),
		.res          (res)
	);

	assign out_ch.entry_number  = res.entry_number;
	assign out_ch.file_offset   = res.file_offset;
	assign out_ch.videos_before = res.videos_before;
	assign out_ch.audio_before  = res.audio_before;
	assign out_ch.last          = res.last;
	assign out_ch.table_full    = res.table_full;
	assign out_ch.overflow      = res.overflow;

endmodule

/* verif/spib_checker.sv */
// Checker that predicts seek entries from accepted index entries and compares the output beats.
module spib_checker import spib_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	spib_in_if               in_ch,
	spib_out_if              out_ch,
	output int               mismatches,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t            regs;
	logic [31:0]     video_count;
	logic [31:0]     audio_bytes;
	logic [31:0]     next_frame;
	logic [31:0]     next_sample;
	logic [31:0]     offset_base;
	logic [15:0]     sample_fraction;
	logic [PM_W-1:0] points_made;
	res_t            queued_points[$];
	res_t            got;
	res_t            want;

	task automatic clear_run();
		video_count     = '0;
		audio_bytes     = '0;
		next_frame      = '0;
		next_sample     = '0;
		sample_fraction = '0;
		points_made     = '0;
		offset_base     = '0;
	endtask

	function automatic logic [PM_W-1:0] table_cap();
		return (regs.entry_limit > MAX_POINTS) ? PM_W'(MAX_POINTS) : regs.entry_limit;
	endfunction

	function automatic logic seek_due(logic is_vid, logic is_aud, logic [31:0] len);
		logic [31:0] reach;
		reach = audio_bytes + len;
		return (points_made < table_cap()) &&
			((is_vid && video_count >= next_frame) || (is_aud && reach > next_sample));
	endfunction

	task automatic walk_entry(input logic restart, input logic [31:0] tag, off, len);
		res_t batch[$];
		res_t r;
		logic is_vid;
		logic is_aud;
		logic more;
		if (restart)
			clear_run();
		if (points_made >= table_cap())
			return;
		if (video_count == 0 && audio_bytes == 0 && points_made == 0)
			offset_base = (off < 32'(regs.stream_start)) ? 32'(regs.stream_start) - 32'd4 : '0;
		is_vid = tag[7:0] == CH_ZERO && tag[15:8] == CH_ZERO && tag[23:16] == CH_D &&
			(tag[31:24] == CH_C || tag[31:24] == CH_B);
		is_aud = regs.audio_enabled && tag[7:0] == CH_ZERO && tag[15:8] == CH_ONE &&
			tag[23:16] == CH_W && tag[31:24] == CH_B;
		while (batch.size() < MAX_PER_ITEM && seek_due(is_vid, is_aud, len)) begin
			r.entry_number  = points_made[EN_W-1:0];
			r.file_offset   = offset_base + off;
			r.videos_before = video_count;
			r.audio_before  = audio_bytes;
			r.last          = 1'b0;
			r.overflow      = 1'b0;
			points_made     = points_made + 1'b1;
			r.table_full    = points_made >= table_cap();
			next_frame      = next_frame + 32'(regs.frame_step);
			next_sample     = next_sample + regs.sample_step;
			sample_fraction = sample_fraction + regs.sample_step_fraction;
			if (sample_fraction >= 16'(regs.frame_rate)) begin
				sample_fraction = sample_fraction - 16'(regs.frame_rate);
				next_sample     = next_sample + 32'd1;
			end
			batch.push_back(r);
		end
		more = batch.size() == MAX_PER_ITEM && seek_due(is_vid, is_aud, len);
		foreach (batch[k]) begin
			batch[k].last     = k == batch.size() - 1;
			batch[k].overflow = more;
			queued_points.push_back(batch[k]);
		end
		if (is_vid)
			video_count = video_count + 32'd1;
		if (is_aud)
			audio_bytes = audio_bytes + len;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{frame_step: 16'd1, sample_step: 32'd0, sample_step_fraction: 16'd0,
				frame_rate: 10'd25, entry_limit: 13'd1, audio_enabled: 1'b0,
				stream_start: 17'd0};
			clear_run();
			queued_points.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_STEP:      regs.frame_step           = cfg_data[15:0];
					REG_SAMPLE_STEP:     regs.sample_step          = cfg_data[31:0];
					REG_SAMPLE_FRACTION: regs.sample_step_fraction = cfg_data[15:0];
					REG_FRAME_RATE:      regs.frame_rate           = cfg_data[9:0];
					REG_ENTRY_LIMIT:     regs.entry_limit          = cfg_data[12:0];
					REG_AUDIO_ENABLED:   regs.audio_enabled        = cfg_data[0];
					REG_STREAM_START:    regs.stream_start         = cfg_data[16:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.entry_number, out_ch.file_offset, out_ch.videos_before,
					out_ch.audio_before, out_ch.last, out_ch.table_full, out_ch.overflow};
				if (queued_points.size() == 0) begin
					if (mismatches < 10)
						$display("%t: unexpected seek beat: entry %0d offset %h", $realtime,
							got.entry_number, got.file_offset);
					mismatches++;
				end else begin
					want = queued_points.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("%t: seek beat mismatch", $realtime);
							$display("  expected entry %0d offset %h videos %0d audio %0d lfo %b%b%b",
								want.entry_number, want.file_offset, want.videos_before,
								want.audio_before, want.last, want.table_full, want.overflow);
							$display("  actual   entry %0d offset %h videos %0d audio %0d lfo %b%b%b",
								got.entry_number, got.file_offset, got.videos_before,
								got.audio_before, got.last, got.table_full, got.overflow);
						end
						mismatches++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				walk_entry(in_ch.restart, in_ch.chunk_tag, in_ch.chunk_offset, in_ch.chunk_length);
			outstanding = queued_points.size();
		end
	end

endmodule

/* verif/tb_seek_point_index_builder_top.sv */
// Testbench top: drives index entries, register writes and output stalls, and gives the verdict.
module tb_seek_point_index_builder_top;
	timeunit 1ns;
	timeprecision 1ps;
	import spib_pkg::*;

	localparam logic [31:0] TAG_VIDEO_DC = {CH_C, CH_D, CH_ZERO, CH_ZERO};
	localparam logic [31:0] TAG_VIDEO_DB = {CH_B, CH_D, CH_ZERO, CH_ZERO};
	localparam logic [31:0] TAG_AUDIO    = {CH_B, CH_W, CH_ONE, CH_ZERO};
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 16;
	localparam int PHASE_ITEMS = 25;
	localparam int IDLE_PCT    = 11;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_FRAME_STEP;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             idle_en = 1'b1;
	int               mismatches;
	int               outstanding;
	int unsigned      cycles = 0;
	cfg_t             cur;
	logic [31:0]      file_pos = '0;

	spib_in_if  in_ch();
	spib_out_if out_ch();

	seek_point_index_builder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	spib_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		in_ch.valid        = 1'b0;
		in_ch.restart      = 1'b0;
		in_ch.chunk_tag    = '0;
		in_ch.chunk_offset = '0;
		in_ch.chunk_length = '0;
		out_ch.ready       = 1'b0;
	end

	always @(negedge clk) begin
		out_ch.ready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_entry(input logic rs, input logic [31:0] tag, off, len);
		while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.restart      <= rs;
		in_ch.chunk_tag    <= tag;
		in_ch.chunk_offset <= off;
		in_ch.chunk_length <= len;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		cur = c;
		put_reg(REG_FRAME_STEP, CFG_W'(c.frame_step));
		put_reg(REG_SAMPLE_STEP, c.sample_step);
		put_reg(REG_SAMPLE_FRACTION, CFG_W'(c.sample_step_fraction));
		put_reg(REG_FRAME_RATE, CFG_W'(c.frame_rate));
		put_reg(REG_ENTRY_LIMIT, CFG_W'(c.entry_limit));
		put_reg(REG_AUDIO_ENABLED, CFG_W'(c.audio_enabled));
		put_reg(REG_STREAM_START, CFG_W'(c.stream_start));
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic roll_settings(output cfg_t c);
		int r;
		r = $urandom_range(0, 99);
		c.frame_step = (r < 8) ? 16'hFFFF : (r < 13) ? 16'd0 : 16'($urandom_range(1, 4));
		r = $urandom_range(0, 99);
		c.sample_step = (r < 10) ? 32'($urandom) : (r < 15) ? 32'd0 :
			32'($urandom_range(200, 3000));
		c.sample_step_fraction = 16'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		c.frame_rate = (r < 10) ? 10'd1000 : (r < 15) ? 10'd1023 : 10'($urandom_range(1, 60));
		r = $urandom_range(0, 99);
		c.entry_limit = (r < 10) ? 13'd4096 : (r < 15) ? 13'h1FFF :
			13'($urandom_range(4, 150));
		c.audio_enabled = $urandom_range(0, 3) != 0;
		c.stream_start = ($urandom_range(0, 9) == 0) ? 17'd65536 : 17'($urandom_range(0, 4000));
	endtask

	task automatic send_random(input logic first);
		logic [31:0] tag;
		logic [31:0] off;
		logic [31:0] len;
		logic        rs;
		int          pick;
		rs = first || ($urandom_range(0, 99) < 5);
		if (rs)
			file_pos = ($urandom_range(0, 1) != 0) ? 32'd4 : 32'(cur.stream_start) + 32'd4;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			tag = TAG_VIDEO_DC;
		else if (pick < 55)
			tag = TAG_VIDEO_DB;
		else if (pick < 80)
			tag = TAG_AUDIO;
		else if (pick < 90)
			tag = (pick[0] ? TAG_AUDIO : TAG_VIDEO_DC) ^ (32'd1 << $urandom_range(0, 31));
		else
			tag = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			len = $urandom;
		else if (pick < 25)
			len = '0;
		else
			len = $urandom_range(0, 8000);
		pick = $urandom_range(0, 99);
		if (pick < 65)
			off = file_pos;
		else if (pick < 85)
			off = $urandom_range(0, 70000);
		else
			off = $urandom;
		file_pos = file_pos + 32'd8 + (len & 32'hFFFF);
		send_entry(rs, tag, off, len);
	endtask

	initial begin
		cfg_t c;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: a single-entry table that fills on the first video chunk.
		cur = cfg_t'{16'd1, 32'd0, 16'd0, 10'd25, 13'd1, 1'b0, 17'd0};
		send_entry(1'b1, TAG_VIDEO_DC, 32'd0, 32'd0);
		send_entry(1'b0, TAG_VIDEO_DC, 32'd8, 32'd100);
		drain();

		program_regs(cfg_t'{16'd1, 32'd1000, 16'd7, 10'd25, 13'd4096, 1'b1, 17'd65536});
		send_entry(1'b1, TAG_AUDIO, 32'd4, 32'd0);
		send_entry(1'b0, TAG_VIDEO_DB, 32'hFFFF_FFFF, 32'd0);
		send_entry(1'b0, TAG_AUDIO, 32'd16, 32'hFFFF_FFFF);
		send_entry(1'b0, TAG_AUDIO, 32'd24, 32'd3000);
		send_entry(1'b0, TAG_VIDEO_DC, 32'd32, 32'd10);
		send_entry(1'b0, {CH_D, CH_D, CH_ZERO, CH_ZERO}, 32'd40, 32'd10);
		send_entry(1'b0, {CH_B, CH_W, CH_ONE, CH_ONE}, 32'd48, 32'd10);
		send_entry(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_entry(1'b0, 32'd0, 32'd0, 32'd0);
		drain();

		program_regs(cfg_t'{16'd0, 32'd0, 16'hFFFF, 10'd0, 13'h1FFF, 1'b0, 17'd0});
		send_entry(1'b1, TAG_VIDEO_DC, 32'd100, 32'd0);
		send_entry(1'b0, TAG_AUDIO, 32'd200, 32'd5000);
		send_entry(1'b0, TAG_VIDEO_DB, 32'd300, 32'd0);
		drain();

		program_regs(cfg_t'{16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 10'd1000, 13'd0, 1'b1, 17'd1});
		send_entry(1'b1, TAG_VIDEO_DC, 32'd0, 32'd0);
		send_entry(1'b0, TAG_AUDIO, 32'd0, 32'hFFFF_FFFF);
		drain();

		program_regs(cfg_t'{16'd2, 32'd500, 16'd3, 10'd1, 13'd3, 1'b1, 17'd100});
		send_entry(1'b1, TAG_VIDEO_DC, 32'd50, 32'd0);
		send_entry(1'b0, TAG_AUDIO, 32'd60, 32'd800);
		send_entry(1'b0, TAG_VIDEO_DC, 32'd70, 32'd0);
		send_entry(1'b0, TAG_VIDEO_DC, 32'd80, 32'd0);
		send_entry(1'b0, TAG_AUDIO, 32'd90, 32'd5000);
		send_entry(1'b1, TAG_AUDIO, 32'd200, 32'd1);
		drain();

		// Random phases; the third one runs with no idling on either side.
		for (int ph = 0; ph < 4; ph++) begin
			roll_settings(c);
			program_regs(c);
			idle_en <= ph != 2;
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_random(k == 0);
			drain();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/spib_pkg.sv
hw/rtl/spib_if.sv
hw/rtl/spib_cfg.sv
hw/rtl/spib_datapath.sv
hw/rtl/spib_ctrl.sv
hw/rtl/seek_point_index_builder_top.sv
verif/spib_checker.sv
verif/tb_seek_point_index_builder_top.sv
